// ===== src/qlu_pkg.sv =====
// Shared types, sizes and codes for the tabular Q-learning update block.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps

package qlu_pkg;

	// Problem sizes.
	localparam int unsigned ROWS    = 8;
	localparam int unsigned COLS    = 8;
	localparam int unsigned ACTIONS = 13;

	localparam int unsigned NUM_STATES  = ROWS * COLS * ROWS * COLS * ACTIONS;
	localparam int unsigned NUM_ENTRIES = NUM_STATES * ACTIONS;
	localparam int unsigned ADDR_W      = $clog2(NUM_ENTRIES);

	// Field widths fixed by the interface.
	localparam int unsigned ACT_W     = 4;
	localparam int unsigned STATE_W   = 16;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned Q_W       = 32;

	// Command codes.
	localparam logic CMD_SELECT = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT          = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THRESHOLD = 2'd2;

	// Configuration reset values.
	localparam logic [CFG_W-1:0] LEARNING_RATE_RST     = 16'd6554;
	localparam logic [CFG_W-1:0] DISCOUNT_RST          = 16'd58982;
	localparam logic [CFG_W-1:0] EXPLORE_THRESHOLD_RST = 16'd3277;

	// Saturation bounds of a Q value.
	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

	// One input beat.
	typedef struct packed {
		logic                      command;
		logic [STATE_W-1:0]        state_index;
		logic [ACT_W-1:0]          action;
		logic signed [15:0]        reward_delta;
		logic [STATE_W-1:0]        next_state_index;
		logic [15:0]               random_draw;
		logic [ACT_W-1:0]          random_action;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic [ACT_W-1:0]          chosen_action;
		logic                      explored;
		logic signed [Q_W-1:0]     chosen_value;
		logic signed [Q_W-1:0]     updated_value;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                      load;
		logic                      clr_en;
		logic [ADDR_W-1:0]         clr_addr;
		logic                      rd_en;
		logic                      rd_scan;
		logic [ACT_W-1:0]          rd_idx;
		logic                      mul1_en;
		logic                      diff_en;
		logic                      mul2_en;
		logic                      fin_en;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic                      is_update;
		logic                      explore;
		logic                      res_free;
	} dp_status_t;

endpackage

// ===== src/qlu_ctrl.sv =====
// Controller state machine of the Q-learning block: clearing pass, row scan,
// entry read and the update arithmetic sequence. Depends on qlu_pkg.
`timescale 1ns / 1ps

module qlu_ctrl import qlu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_START = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_ENTRY = 4'd4;
	localparam logic [3:0] ST_WAIT  = 4'd5;
	localparam logic [3:0] ST_MUL1  = 4'd6;
	localparam logic [3:0] ST_DIFF  = 4'd7;
	localparam logic [3:0] ST_MUL2  = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0]        state_q, state_d;
	logic [ACT_W-1:0]  idx_q, idx_d;
	logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

	// Input beats are taken only while idle.
	assign item_stall = (state_q != ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		clr_addr_d = clr_addr_q;
		cmd        = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en   = 1'b1;
				cmd.clr_addr = clr_addr_q;
				clr_addr_d   = clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(NUM_ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				idx_d = '0;
				if (status.is_update || !status.explore) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_ENTRY;
				end
			end
			ST_SCAN: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_scan = 1'b1;
				cmd.rd_idx  = idx_q;
				idx_d       = idx_q + 1'b1;
				if (idx_q == ACT_W'(ACTIONS - 1)) begin
					idx_d   = '0;
					state_d = status.is_update ? ST_ENTRY : ST_WAIT;
				end
			end
			ST_ENTRY: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				state_d = status.is_update ? ST_MUL1 : ST_FIN;
			end
			ST_MUL1: begin
				cmd.mul1_en = 1'b1;
				state_d     = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d     = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2_en = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// Hold here while the result register is still occupied.
				if (status.res_free) begin
					cmd.fin_en = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			idx_q      <= '0;
			clr_addr_q <= '0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			clr_addr_q <= clr_addr_d;
		end
	end

endmodule

// ===== src/qlu_dp.sv =====
// Datapath of the Q-learning block: Q table memory, configuration registers,
// row maximum tracker, fixed-point update arithmetic and result register.
// Depends on qlu_pkg; driven by qlu_ctrl.
`timescale 1ns / 1ps

module qlu_dp import qlu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  item_t                item,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           status,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result
);

	item_t                item_q;
	logic [ADDR_W-1:0]    scan_base_q;
	logic [ADDR_W-1:0]    entry_base_q;
	logic                 scan_oob_q;
	logic                 st_oob_q;
	logic [CFG_W-1:0]     lr_q;
	logic [CFG_W-1:0]     disc_q;
	logic [CFG_W-1:0]     thr_q;

	logic [STATE_W-1:0]   scan_state;
	logic [ACT_W-1:0]     ract_cl;
	logic [ACT_W-1:0]     ent_act;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]    wr_addr;
	logic [Q_W-1:0]       wr_data;
	logic                 wr_en;

	logic [Q_W-1:0]       q_mem [NUM_ENTRIES];
	logic [Q_W-1:0]       rd_data_s1;
	logic                 rd_valid_s1;
	logic                 rd_scan_s1;
	logic [ACT_W-1:0]     rd_idx_s1;
	logic signed [Q_W-1:0] rd_val;

	logic signed [Q_W-1:0] max_val_q;
	logic [ACT_W-1:0]     max_idx_q;
	logic signed [Q_W-1:0] ent_val_q;

	logic signed [48:0]   prod1_q;
	logic signed [31:0]   disc_term;
	logic signed [32:0]   target;
	logic signed [33:0]   diff_q;
	logic signed [50:0]   prod2_q;
	logic signed [33:0]   lr_term;
	logic signed [35:0]   new_val;
	logic signed [Q_W-1:0] sat_val;

	logic                 explore;
	logic                 explored_now;
	logic                 upd_ok;
	result_t              res_d;
	result_t              res_q;
	logic                 res_valid_q;

	// Row whose maximum is searched: the next state on update, else the state.
	assign scan_state = (item.command == CMD_UPDATE) ? item.next_state_index
		: item.state_index;

	// Capture the accepted beat and precompute row base addresses.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q       <= item;
			scan_base_q  <= ADDR_W'(scan_state) * ADDR_W'(ACTIONS);
			entry_base_q <= ADDR_W'(item.state_index) * ADDR_W'(ACTIONS);
			scan_oob_q   <= {16'b0, scan_state} >= 32'(NUM_STATES);
			st_oob_q     <= {16'b0, item.state_index} >= 32'(NUM_STATES);
		end
	end

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= LEARNING_RATE_RST;
			disc_q <= DISCOUNT_RST;
			thr_q  <= EXPLORE_THRESHOLD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LEARNING_RATE:     lr_q   <= cfg_data;
				CFG_DISCOUNT:          disc_q <= cfg_data;
				CFG_EXPLORE_THRESHOLD: thr_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Action decode for the single entry access.
	assign explore      = item_q.random_draw < thr_q;
	assign explored_now = (item_q.command == CMD_SELECT) && explore;
	assign ract_cl      = (item_q.random_action >= ACT_W'(ACTIONS)) ?
		ACT_W'(ACTIONS - 1) : item_q.random_action;
	assign ent_act      = (item_q.command == CMD_UPDATE) ? item_q.action : ract_cl;
	assign upd_ok       = (item_q.command == CMD_UPDATE) && !st_oob_q &&
		(item_q.action < ACT_W'(ACTIONS));

	// Memory ports: one read and one write per cycle.
	assign rd_addr = cmd.rd_scan ? (scan_base_q + ADDR_W'(cmd.rd_idx))
		: (entry_base_q + ADDR_W'(ent_act));
	assign wr_en   = cmd.clr_en || (cmd.fin_en && upd_ok);
	assign wr_addr = cmd.clr_en ? cmd.clr_addr : (entry_base_q + ADDR_W'(item_q.action));
	assign wr_data = cmd.clr_en ? '0 : sat_val;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= q_mem[rd_addr];
		end
	end

	// Tag that travels with each read to the data cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_scan_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			rd_scan_s1  <= cmd.rd_scan;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cmd.rd_idx;
	end

	// A state beyond the table reads as a row of zeros.
	assign rd_val = (rd_scan_s1 ? scan_oob_q : st_oob_q) ? '0 : $signed(rd_data_s1);

	// Lowest-index maximum of the scanned row, and the single entry value.
	always_ff @(posedge clk) begin
		if (rd_valid_s1 && rd_scan_s1) begin
			if ((rd_idx_s1 == '0) || (rd_val > max_val_q)) begin
				max_val_q <= rd_val;
				max_idx_q <= rd_idx_s1;
			end
		end
		if (rd_valid_s1 && !rd_scan_s1) begin
			ent_val_q <= rd_val;
		end
	end

	// Update arithmetic: discount product, difference, learning-rate product.
	assign disc_term = $signed(prod1_q[47:16]);
	assign target    = $signed({item_q.reward_delta[15], item_q.reward_delta, 16'b0}) +
		$signed({disc_term[31], disc_term});
	assign lr_term   = $signed(prod2_q[49:16]);
	assign new_val   = $signed({{4{ent_val_q[31]}}, ent_val_q}) +
		$signed({{2{lr_term[33]}}, lr_term});

	always_ff @(posedge clk) begin
		if (cmd.mul1_en) begin
			prod1_q <= $signed({1'b0, disc_q}) * max_val_q;
		end
		if (cmd.diff_en) begin
			diff_q <= $signed({target[32], target}) -
				$signed({{2{ent_val_q[31]}}, ent_val_q});
		end
		if (cmd.mul2_en) begin
			prod2_q <= $signed({1'b0, lr_q}) * diff_q;
		end
	end

	// Saturate the new value to 32 bits.
	always_comb begin
		if (new_val[35:31] == {5{new_val[35]}}) begin
			sat_val = new_val[31:0];
		end else begin
			sat_val = new_val[35] ? Q_MIN : Q_MAX;
		end
	end

	// Result assembly.
	always_comb begin
		res_d.chosen_action = explored_now ? ract_cl : max_idx_q;
		res_d.explored      = explored_now;
		res_d.chosen_value  = explored_now ? ent_val_q : max_val_q;
		res_d.updated_value = upd_ok ? sat_val : '0;
	end

	// Output register: holds one finished beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.fin_en) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_en) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign status.is_update = (item_q.command == CMD_UPDATE);
	assign status.explore   = explore;
	assign status.res_free  = !res_valid_q || !result_stall;

endmodule

// ===== src/tabular_q_learning_update.sv =====
// Top level of the tabular Q-learning block: joins controller and datapath.
// Depends on qlu_pkg, qlu_ctrl and qlu_dp.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------
//   item     | in        | item_valid / item_stall | item (item_t)
//   result   | out       | result_valid/result_stall| result (result_t)
//   cfg      | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// For a greedy select or an update, the row scan, one Q table read per action
// over the single read port, sets most of the time from accept to next accept;
// an exploring select skips the scan and reads a single entry.
// After reset the table is cleared one entry a cycle, all 692224 entries, with
// item_stall high; configuration writes are taken at all times.
// A stalled result sits in the output register while the next beat is taken.
`timescale 1ns / 1ps

module tabular_q_learning_update import qlu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Registers accept a write in any cycle.
	assign cfg_ready = 1'b1;

	qlu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	qlu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== src/qlu_checker.sv =====
// Port-level checks for the tabular Q-learning block, bound to the top level.
// Depends on qlu_pkg.
`timescale 1ns / 1ps

module qlu_checker import qlu_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input result_t              result
);

	// A stalled result beat stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// The block is busy in the cycle after it takes an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken twice in a row");

	// A select that explored never reports an updated value.
	a_explore_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.explored |-> result.updated_value == '0)
		else $error("exploring select reports an update");

	// Every reported action is a real action.
	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.chosen_action < ACT_W'(ACTIONS))
		else $error("chosen action out of range");

endmodule

bind tabular_q_learning_update qlu_checker u_qlu_checker (.*);
